@@ rtl/mppt_pkg.sv @@
package mppt_pkg;

	// coordinate storage width of the cursor registers
	localparam int COORD_WIDTH = 10;
	// width of the limit registers and of the output coordinates
	localparam int LIMIT_WIDTH = 10;
	// common width wide enough for both
	localparam int EXT_WIDTH = (COORD_WIDTH > LIMIT_WIDTH) ? COORD_WIDTH : LIMIT_WIDTH;
	// signed sum width: extended coordinate plus sign and carry
	localparam int SUM_WIDTH = EXT_WIDTH + 2;

	localparam int BYTE_WIDTH = 8;
	localparam int BUTTON_WIDTH = 3;
	localparam int IN_TDATA_WIDTH = 8;
	localparam int OUT_TDATA_WIDTH = 24;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LIMIT_WIDTH-1:0] X_LIMIT_RESET = LIMIT_WIDTH'(631);
	localparam logic [LIMIT_WIDTH-1:0] Y_LIMIT_RESET = LIMIT_WIDTH'(468);
	localparam logic [COORD_WIDTH-1:0] X_START = COORD_WIDTH'(320);
	localparam logic [COORD_WIDTH-1:0] Y_START = COORD_WIDTH'(240);
	localparam logic [BYTE_WIDTH-1:0] BUTTON_MASK = 8'h07;

	// configuration register indexes
	localparam logic REG_X_LIMIT = 1'b0;
	localparam logic REG_Y_LIMIT = 1'b1;

	// position of the next byte within a packet
	typedef enum logic [1:0] {
		SLOT_FLAGS = 2'd0,
		SLOT_DX    = 2'd1,
		SLOT_DY    = 2'd2
	} slot_t;

	// one assembled packet
	typedef struct packed {
		logic [BUTTON_WIDTH-1:0] buttons;
		logic [BYTE_WIDTH-1:0]   dx;
		logic [BYTE_WIDTH-1:0]   dy;
	} packet_t;

endpackage

@@ rtl/mppt_front.sv @@
module mppt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mppt_pkg::BYTE_WIDTH-1:0] in_byte,
	input  logic                         queue_space,
	output logic                         push,
	output mppt_pkg::packet_t            push_pkt
);

	mppt_pkg::slot_t slot_q, slot_next;
	logic [mppt_pkg::BUTTON_WIDTH-1:0] flags_q;
	logic [mppt_pkg::BYTE_WIDTH-1:0]   dx_q;
	logic last_byte;
	logic accept;

	// the packet-completing byte needs room in the queue
	always_comb begin
		unique case (slot_q)
			mppt_pkg::SLOT_FLAGS: last_byte = 1'b0;
			mppt_pkg::SLOT_DX:    last_byte = 1'b0;
			default:              last_byte = 1'b1;
		endcase
	end

	assign in_ready = !last_byte || queue_space;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last_byte;

	// next slot
	always_comb begin
		slot_next = slot_q;
		if (accept) begin
			unique case (slot_q)
				mppt_pkg::SLOT_FLAGS: slot_next = mppt_pkg::SLOT_DX;
				mppt_pkg::SLOT_DX:    slot_next = mppt_pkg::SLOT_DY;
				default:              slot_next = mppt_pkg::SLOT_FLAGS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= mppt_pkg::SLOT_FLAGS;
		end else begin
			slot_q <= slot_next;
		end
	end

	// hold the flags and dx bytes until dy arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			dx_q    <= '0;
		end else if (accept) begin
			if (slot_q == mppt_pkg::SLOT_FLAGS) begin
				flags_q <= in_byte[mppt_pkg::BUTTON_WIDTH-1:0];
			end
			if (slot_q == mppt_pkg::SLOT_DX) begin
				dx_q <= in_byte;
			end
		end
	end

	assign push_pkt.buttons = flags_q;
	assign push_pkt.dx      = dx_q;
	assign push_pkt.dy      = in_byte;

endmodule

@@ rtl/mppt_queue.sv @@
module mppt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mppt_pkg::packet_t push_pkt,
	output logic              space,
	output logic              valid,
	input  logic              pop,
	output mppt_pkg::packet_t pop_pkt
);

	mppt_pkg::packet_t entry_q [mppt_pkg::QUEUE_DEPTH];
	logic [mppt_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
	logic [mppt_pkg::QUEUE_CNT_WIDTH-1:0] count_q;

	assign space   = count_q != mppt_pkg::QUEUE_CNT_WIDTH'(mppt_pkg::QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign pop_pkt = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mppt_pkg::QUEUE_PTR_WIDTH'(mppt_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mppt_pkg::QUEUE_PTR_WIDTH'(mppt_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_pkt;
		end
	end

endmodule

@@ rtl/mppt_back.sv @@
module mppt_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pkt_valid,
	output logic                                pop,
	input  mppt_pkg::packet_t                   pkt,
	input  logic [mppt_pkg::LIMIT_WIDTH-1:0]    x_limit,
	input  logic [mppt_pkg::LIMIT_WIDTH-1:0]    y_limit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mppt_pkg::LIMIT_WIDTH-1:0]    out_x,
	output logic [mppt_pkg::LIMIT_WIDTH-1:0]    out_y,
	output logic [mppt_pkg::BUTTON_WIDTH-1:0]   out_buttons
);

	localparam int EW = mppt_pkg::EXT_WIDTH;
	localparam int SW = mppt_pkg::SUM_WIDTH;
	localparam int CW = mppt_pkg::COORD_WIDTH;
	localparam int LW = mppt_pkg::LIMIT_WIDTH;

	logic [CW-1:0] cursor_x_q, cursor_y_q;
	logic          out_valid_q;
	logic [LW-1:0] out_x_q, out_y_q;
	logic [mppt_pkg::BUTTON_WIDTH-1:0] out_buttons_q;

	logic signed [SW-1:0] sum_x, sum_y, lim_x, lim_y;
	logic [EW-1:0] clamp_x, clamp_y;

	assign pop = pkt_valid && (!out_valid_q || out_ready);

	// x adds dx, y subtracts dy
	assign sum_x = $signed({2'b00, EW'(cursor_x_q)}) + SW'($signed(pkt.dx));
	assign sum_y = $signed({2'b00, EW'(cursor_y_q)}) - SW'($signed(pkt.dy));
	assign lim_x = $signed({2'b00, EW'(x_limit)});
	assign lim_y = $signed({2'b00, EW'(y_limit)});

	// saturate to 0 .. limit
	always_comb begin
		if (sum_x < 0) begin
			clamp_x = '0;
		end else if (sum_x > lim_x) begin
			clamp_x = EW'(x_limit);
		end else begin
			clamp_x = sum_x[EW-1:0];
		end
		if (sum_y < 0) begin
			clamp_y = '0;
		end else if (sum_y > lim_y) begin
			clamp_y = EW'(y_limit);
		end else begin
			clamp_y = sum_y[EW-1:0];
		end
	end

	// cursor and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= mppt_pkg::X_START;
			cursor_y_q  <= mppt_pkg::Y_START;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cursor_x_q <= clamp_x[CW-1:0];
				cursor_y_q <= clamp_y[CW-1:0];
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, zero-extended through the stored width
	logic [EW-1:0] new_x_ext, new_y_ext;
	assign new_x_ext = EW'(clamp_x[CW-1:0]);
	assign new_y_ext = EW'(clamp_y[CW-1:0]);

	always_ff @(posedge clk) begin
		if (pop) begin
			out_x_q       <= new_x_ext[LW-1:0];
			out_y_q       <= new_y_ext[LW-1:0];
			out_buttons_q <= pkt.buttons;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_buttons = out_buttons_q;

endmodule

@@ rtl/mouse_packet_position_tracker.sv @@
// a completed packet passes through the packet queue and then the output register
// throughput: one byte per cycle, one result per three bytes; the front end takes a byte
//   every cycle and the back end clears one packet per cycle, so only a stalled output,
//   once the two-entry packet queue is full, holds off the dy byte
// reset: byte slot back to the flags byte, cursor at 320,240, limits 631 and 468,
//   queue and output register empty
module mouse_packet_position_tracker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [mppt_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,  // [7:0] rx_byte
	output logic m_tvalid,
	input  logic m_tready,
	output logic [mppt_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,  // [9:0] pos_x, [19:10] pos_y,
	                                                       // [22:20] button_bits, [23] zero
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [mppt_pkg::LIMIT_WIDTH-1:0] cfg_data
);

	logic [mppt_pkg::LIMIT_WIDTH-1:0] x_limit_q, y_limit_q;
	logic queue_space, queue_valid, push, pop;
	mppt_pkg::packet_t push_pkt, pop_pkt;
	logic [mppt_pkg::LIMIT_WIDTH-1:0]  pos_x, pos_y;
	logic [mppt_pkg::BUTTON_WIDTH-1:0] button_bits;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= mppt_pkg::X_LIMIT_RESET;
			y_limit_q <= mppt_pkg::Y_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mppt_pkg::REG_X_LIMIT: x_limit_q <= cfg_data;
				mppt_pkg::REG_Y_LIMIT: y_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mppt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata[mppt_pkg::BYTE_WIDTH-1:0]),
		.queue_space (queue_space),
		.push        (push),
		.push_pkt    (push_pkt)
	);

	mppt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.space    (queue_space),
		.valid    (queue_valid),
		.pop      (pop),
		.pop_pkt  (pop_pkt)
	);

	mppt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt_valid   (queue_valid),
		.pop         (pop),
		.pkt         (pop_pkt),
		.x_limit     (x_limit_q),
		.y_limit     (y_limit_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_x       (pos_x),
		.out_y       (pos_y),
		.out_buttons (button_bits)
	);

	// pack result fields, lowest first
	assign m_tdata = {1'b0, button_bits, pos_y, pos_x};

endmodule

@@ tb/mouse_packet_position_tracker_tb.sv @@
`timescale 1ns / 1ps

module mouse_packet_position_tracker_tb;

	// one cursor report as it leaves the block
	typedef struct packed {
		logic [mppt_pkg::LIMIT_WIDTH-1:0]  x;
		logic [mppt_pkg::LIMIT_WIDTH-1:0]  y;
		logic [mppt_pkg::BUTTON_WIDTH-1:0] buttons;
	} cursor_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mppt_pkg::IN_TDATA_WIDTH-1:0] s_tdata = '0;    // [7:0] rx_byte
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mppt_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;        // [9:0] pos_x, [19:10] pos_y,
	                                                      // [22:20] button_bits, [23] zero
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [mppt_pkg::LIMIT_WIDTH-1:0] cfg_data = '0;

	// bytes waiting to be sent and reports waiting to be seen
	logic [mppt_pkg::BYTE_WIDTH-1:0] byte_queue[$];
	cursor_report_t expected_reports[$];

	// tracker state as the testbench sees it
	mppt_pkg::slot_t                  next_slot = mppt_pkg::SLOT_FLAGS;
	logic [mppt_pkg::BYTE_WIDTH-1:0]  kept_flags = '0;
	logic [mppt_pkg::BYTE_WIDTH-1:0]  kept_dx = '0;
	logic [mppt_pkg::COORD_WIDTH-1:0] cur_x = mppt_pkg::X_START;
	logic [mppt_pkg::COORD_WIDTH-1:0] cur_y = mppt_pkg::Y_START;
	logic [mppt_pkg::LIMIT_WIDTH-1:0] x_bound = mppt_pkg::X_LIMIT_RESET;
	logic [mppt_pkg::LIMIT_WIDTH-1:0] y_bound = mppt_pkg::Y_LIMIT_RESET;

	int mismatch_count = 0;
	int bytes_accepted = 0;
	int reports_checked = 0;
	int limit_writes = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	mouse_packet_position_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// saturate a signed sum to 0..lim
	function automatic logic [mppt_pkg::COORD_WIDTH-1:0] clamp_to(input int v,
		input logic [mppt_pkg::LIMIT_WIDTH-1:0] lim);
		if (v < 0)
			return '0;
		if (v > int'(lim))
			return mppt_pkg::COORD_WIDTH'(lim);
		return mppt_pkg::COORD_WIDTH'(v);
	endfunction

	// advance the packet assembly by one byte, queue a report on the dy byte
	function automatic void track_byte(input logic [mppt_pkg::BYTE_WIDTH-1:0] b);
		int nx;
		int ny;
		cursor_report_t rep;
		case (next_slot)
			mppt_pkg::SLOT_FLAGS: begin
				kept_flags = b;
				next_slot = mppt_pkg::SLOT_DX;
			end
			mppt_pkg::SLOT_DX: begin
				kept_dx = b;
				next_slot = mppt_pkg::SLOT_DY;
			end
			default: begin
				next_slot = mppt_pkg::SLOT_FLAGS;
				nx = int'(cur_x) + int'($signed(kept_dx));
				ny = int'(cur_y) - int'($signed(b));
				cur_x = clamp_to(nx, x_bound);
				cur_y = clamp_to(ny, y_bound);
				rep.x = mppt_pkg::LIMIT_WIDTH'(cur_x);
				rep.y = mppt_pkg::LIMIT_WIDTH'(cur_y);
				rep.buttons = kept_flags[mppt_pkg::BUTTON_WIDTH-1:0];
				expected_reports.push_back(rep);
			end
		endcase
	endfunction

	// byte driver: random gap after each byte, with bursts of back-to-back bytes
	always @(posedge clk or negedge arst_n) begin : byte_driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				track_byte(s_tdata);
				bytes_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					s_tvalid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (byte_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= byte_queue.pop_front();
					if ($urandom_range(0, 15) == 0)
						tx_burst = !tx_burst;
					tx_gap <= tx_burst ? 0 : $urandom_range(0, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// report monitor: field compare against the oldest expectation, random stalls
	always @(posedge clk or negedge arst_n) begin : report_monitor
		cursor_report_t seen;
		cursor_report_t want;
		int n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.x = m_tdata[9:0];
				seen.y = m_tdata[19:10];
				seen.buttons = m_tdata[22:20];
				reports_checked++;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report x=%0d y=%0d buttons=%0d",
						$time, seen.x, seen.y, seen.buttons);
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					if (seen.x != want.x) begin
						$display("%0t: pos_x expected %0d actual %0d", $time, want.x, seen.x);
						mismatch_count++;
					end
					if (seen.y != want.y) begin
						$display("%0t: pos_y expected %0d actual %0d", $time, want.y, seen.y);
						mismatch_count++;
					end
					if (seen.buttons != want.buttons) begin
						$display("%0t: button_bits expected %0d actual %0d",
							$time, want.buttons, seen.buttons);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				n = rx_burst ? 0 : $urandom_range(0, 19);
				rx_stall <= n;
				m_tready <= (n == 0);
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				m_tready <= (rx_stall == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_packet(input logic [7:0] flags, input logic [7:0] dx,
		input logic [7:0] dy);
		byte_queue.push_back(flags);
		byte_queue.push_back(dx);
		byte_queue.push_back(dy);
	endtask

	// hold off until every byte is in and every report is out, then let the pipe empty
	task automatic wait_drained();
		do
			@(negedge clk);
		while (byte_queue.size() != 0 || s_tvalid || expected_reports.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [mppt_pkg::LIMIT_WIDTH-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mppt_pkg::REG_X_LIMIT)
			x_bound = val;
		else
			y_bound = val;
		limit_writes++;
	endtask

	// limit choice per phase: both extremes, tiny, anywhere, x reset value
	function automatic logic [mppt_pkg::LIMIT_WIDTH-1:0] pick_limit(input int sel);
		case (sel % 5)
			0: return mppt_pkg::LIMIT_WIDTH'(1023);
			1: return '0;
			2: return mppt_pkg::LIMIT_WIDTH'($urandom_range(0, 15));
			3: return mppt_pkg::LIMIT_WIDTH'($urandom_range(0, 1023));
			default: return mppt_pkg::X_LIMIT_RESET;
		endcase
	endfunction

	// delta byte: any, non-negative only, negative only, or a small step
	function automatic logic [7:0] rand_delta(input int mode);
		int d;
		case (mode)
			1: return 8'($urandom_range(0, 127));
			2: return 8'($urandom_range(128, 255));
			3: begin
				d = int'($urandom_range(0, 8)) - 4;
				return 8'(d);
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// stimulus and end of run
	initial begin : stimulus
		int mx;
		int my;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// full swings at reset limits, saturating y high
		push_packet(8'h07, 8'h7F, 8'h80);
		push_packet(8'hF8, 8'h80, 8'h7F);
		push_packet(8'h05, 8'h7F, 8'h80);
		push_packet(8'h05, 8'h7F, 8'h80);
		wait_drained();

		// limits lowered below the cursor, then pushing below zero
		write_limit(mppt_pkg::REG_X_LIMIT, '0);
		write_limit(mppt_pkg::REG_Y_LIMIT, '0);
		push_packet(8'h02, 8'h00, 8'h00);
		push_packet(8'hAA, 8'h80, 8'h7F);
		wait_drained();

		// widest limits, then one step under zero on x
		write_limit(mppt_pkg::REG_X_LIMIT, mppt_pkg::LIMIT_WIDTH'(1023));
		write_limit(mppt_pkg::REG_Y_LIMIT, mppt_pkg::LIMIT_WIDTH'(1023));
		push_packet(8'h01, 8'h7F, 8'h80);
		push_packet(8'h04, 8'h80, 8'h7F);
		wait_drained();

		// random phases, each with its own limits and drift direction
		for (int phase = 0; phase < 8; phase++) begin
			write_limit(mppt_pkg::REG_X_LIMIT, pick_limit(phase));
			write_limit(mppt_pkg::REG_Y_LIMIT, pick_limit(phase + 3));
			mx = $urandom_range(0, 3);
			my = $urandom_range(0, 3);
			for (int k = 0; k < 46; k++) begin
				if ($urandom_range(0, 9) < 7)
					push_packet(8'($urandom_range(0, 255)), rand_delta(mx), rand_delta(my));
				else
					push_packet(8'($urandom_range(0, 255)), rand_delta(0), rand_delta(0));
			end
			wait_drained();
		end

		$display("covered %0d bytes, %0d cursor reports, %0d limit writes",
			bytes_accepted, reports_checked, limit_writes);
		$display("limits swept through 0, 1023, small, random and reset values");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("timeout with %0d reports outstanding", expected_reports.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mppt_pkg.sv
rtl/mppt_front.sv
rtl/mppt_queue.sv
rtl/mppt_back.sv
rtl/mouse_packet_position_tracker.sv
tb/mouse_packet_position_tracker_tb.sv
